// ===== rtl/core/bspc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspc_pkg
// Shared types for the bounded stack with palindrome check: request and
// status codes, controller states and the command/status bundles between
// controller and datapath.
// ----------------------------------------------------------------------------
package bspc_pkg;

    localparam int unsigned ItemW = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CHECK = 2'd2,
        OP_DUMP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_OUT,
        S_CHK_CMP,
        S_CHK_RD,
        S_CHK_OUT,
        S_DMP_OUT,
        S_DMP_RD
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    push;       // write value at top, count up
        logic    pop;        // count down
        logic    idx_clr;    // clear walk index
        logic    idx_inc;    // advance walk index
        logic    match_set;  // start a palindrome compare
        logic    cmp;        // fold current mirror pair into match
        logic    emit;       // load output register
        t_status emit_status;
        logic    emit_item;  // 1: item from read port B, 0: zero
        logic    emit_pal;   // 1: flag from match register, 0: zero
        logic    emit_last;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic single;     // exactly one element held
        logic pair_last;  // current mirror pair is the final one
        logic dump_last;  // current dump element is the bottom one
        logic out_free;   // output register can take a result this cycle
    } t_stat;

endpackage

// ===== rtl/core/bounded_stack_palindrome_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_palindrome_check_unit
// Bounded LIFO stack of signed 32-bit integers: push, pop, palindrome check
// over all mirror pairs, and a top-to-bottom dump.
//
//   channel   dir  tdata                         tuser          tlast
//   s_axis    in   [31:0] value                  [1:0] operation  -
//   m_axis    out  [31:0] item, [32] palindrome  [1:0] status     last
//
// One request is in work at a time; ready is low until it has finished.
// Push and every request on an empty stack are answered from the idle
// state; pop, check and dump results come through the memory's registered
// read ports. Reset clears the fill count and the control state; the
// element memory is not cleared.
// A stalled output holds the controller in its emit state.
// ----------------------------------------------------------------------------
module bounded_stack_palindrome_check_unit #(
    parameter int unsigned DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] item, [32] is_palindrome, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // last
);
    import bspc_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    t_status          w_out_status;
    logic [ItemW-1:0] w_out_item;
    logic             w_out_pal;

    bspc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_op    (t_op'(s_axis_tuser)),
        .o_req_ready (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bspc_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_value      (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (w_out_status),
        .o_out_item   (w_out_item),
        .o_out_pal    (w_out_pal),
        .o_out_last   (m_axis_tlast)
    );

    // Pack result fields
    assign m_axis_tdata = {7'd0, w_out_pal, w_out_item};
    assign m_axis_tuser = w_out_status;

endmodule

// ===== rtl/core/bspc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspc_dpath
// Datapath: element memory with one write and two registered read ports,
// fill count, walk index, palindrome match flag and the output register.
// ----------------------------------------------------------------------------
module bspc_dpath #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bspc_pkg::t_cmd               i_cmd,
    output bspc_pkg::t_stat              o_stat,
    input  logic [bspc_pkg::ItemW-1:0]   i_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output bspc_pkg::t_status            o_out_status,
    output logic [bspc_pkg::ItemW-1:0]   o_out_item,
    output logic                         o_out_pal,
    output logic                         o_out_last
);
    import bspc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [ItemW-1:0] r_mem [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_idx;
    logic             r_match;
    logic [ItemW-1:0] r_rd_a;
    logic [ItemW-1:0] r_rd_b;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [ItemW-1:0] r_out_item;
    logic             r_out_pal;
    logic             r_out_last;

    logic [CW-1:0]    w_rev;
    logic [CW-1:0]    w_idx_nx;

    // Mirror address: count - 1 - idx (top of stack when idx is zero)
    assign w_rev    = r_count - r_idx - CW'(1);
    assign w_idx_nx = r_idx + CW'(1);

    // Status toward the controller
    always_comb begin
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count == CW'(DEPTH));
        o_stat.single    = (r_count == CW'(1));
        o_stat.pair_last = (w_idx_nx == (r_count >> 1));
        o_stat.dump_last = (w_idx_nx == r_count);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // Element memory: write on push, read both ports every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= i_value;
        end
        r_rd_a <= r_mem[r_idx[AW-1:0]];
        r_rd_b <= r_mem[w_rev[AW-1:0]];
    end

    // Count, index and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_match <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= w_idx_nx;
            end
            if (i_cmd.match_set) begin
                r_match <= 1'b1;
            end else if (i_cmd.cmp && (r_rd_a != r_rd_b)) begin
                r_match <= 1'b0;
            end
        end
    end

    // Output register: load on emit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_item   <= i_cmd.emit_item ? r_rd_b : '0;
            r_out_pal    <= i_cmd.emit_pal & r_match;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_item   = r_out_item;
    assign o_out_pal    = r_out_pal;
    assign o_out_last   = r_out_last;

endmodule

// ===== rtl/core/bspc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspc_ctrl
// Controller: takes one request at a time, sequences the pop, palindrome
// walk and dump, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module bspc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  bspc_pkg::t_op   i_req_op,
    output logic            o_req_ready,
    input  bspc_pkg::t_stat i_stat,
    output bspc_pkg::t_cmd  o_cmd
);
    import bspc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Accept only in idle with room in the output register
    assign w_accept = i_req_valid && (r_state == S_IDLE) && i_stat.out_free;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req_op)
                        OP_POP: begin
                            if (!i_stat.empty) n_state = S_POP_OUT;
                        end
                        OP_CHECK: begin
                            if (!i_stat.empty) begin
                                n_state = i_stat.single ? S_CHK_OUT : S_CHK_CMP;
                            end
                        end
                        OP_DUMP: begin
                            if (!i_stat.empty) n_state = S_DMP_OUT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_POP_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_CHK_CMP: begin
                n_state = i_stat.pair_last ? S_CHK_OUT : S_CHK_RD;
            end
            S_CHK_RD: begin
                n_state = S_CHK_CMP;
            end
            S_CHK_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_DMP_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.dump_last ? S_IDLE : S_DMP_RD;
                end
            end
            S_DMP_RD: begin
                n_state = S_DMP_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_req_ready       = 1'b0;
        o_cmd             = '0;
        o_cmd.emit_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_req_ready = i_stat.out_free;
                if (w_accept) begin
                    o_cmd.emit_last = 1'b1;
                    case (i_req_op)
                        OP_PUSH: begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.emit_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (i_stat.empty) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = ST_UNDERFLOW;
                            end else begin
                                o_cmd.pop = 1'b1;
                            end
                        end
                        OP_CHECK: begin
                            if (i_stat.empty) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.match_set = 1'b1;
                            end
                        end
                        default: begin
                            if (i_stat.empty) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_POP_OUT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_item = 1'b1;
                o_cmd.emit_last = 1'b1;
            end
            S_CHK_CMP: begin
                o_cmd.cmp     = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            S_CHK_OUT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_pal  = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.idx_clr   = i_stat.out_free;
            end
            S_DMP_OUT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_item = 1'b1;
                o_cmd.emit_last = i_stat.dump_last;
                o_cmd.idx_inc   = i_stat.out_free;
                o_cmd.idx_clr   = i_stat.out_free && i_stat.dump_last;
            end
            default: begin
                o_cmd = o_cmd;
            end
        endcase
    end

endmodule

// ===== tb/bounded_stack_palindrome_check_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_palindrome_check_unit_test
// Self-checking bench for the bounded stack with palindrome check. A driver
// sends push, pop, check and dump requests from a queue, a shadow stack
// predicts every result, and a monitor compares each output transfer field
// by field. A directed opening hits the empty, full and single-element cases
// and a mismatch on an inner mirror pair. Random palindrome runs and noise
// follow under four idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module bounded_stack_palindrome_check_unit_test;
    import bspc_pkg::*;

    localparam int unsigned StackDepth = 8;
    localparam int unsigned HangLimit = 5000;
    localparam int unsigned RandomPerPhase = 60;
    localparam int unsigned MaxPrinted = 40;
    localparam logic [31:0] MinInt = 32'h8000_0000;
    localparam logic [31:0] MaxInt = 32'h7FFF_FFFF;

    typedef struct packed {
        t_op         op;
        logic [31:0] value;
    } t_stack_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] item;
        logic        pal;
        logic        last;
    } t_stack_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] item, [32] is_palindrome, rest zero
    logic [1:0]  m_axis_tuser;        // [1:0] status
    logic        m_axis_tlast;

    t_stack_request stack_requests[$];
    t_stack_reply   stack_replies[$];

    // Shadow of the block's stack, updated at every accepted request
    logic [31:0] shadow_stack[StackDepth];
    int unsigned shadow_fill = 0;

    // Fill level as seen by the request generator
    int unsigned planned_fill = 0;
    int unsigned requests_queued = 0;
    int unsigned requests_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned hang_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    bounded_stack_palindrome_check_unit #(
        .DEPTH(StackDepth)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MaxPrinted) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got,
                     want);
        end
    endtask

    function automatic t_stack_reply make_reply(input t_status status, input logic [31:0] item,
                                                input logic pal, input logic last);
        t_stack_reply r;
        r.status = status;
        r.item = item;
        r.pal = pal;
        r.last = last;
        return r;
    endfunction

    // Work out the results of one request and advance the shadow stack
    function automatic void apply_stack_request(input t_op op, input logic [31:0] value);
        logic        mirrored;
        int unsigned i;
        case (op)
            OP_PUSH: begin
                if (shadow_fill >= StackDepth) begin
                    stack_replies.push_back(make_reply(ST_OVERFLOW, '0, 1'b0, 1'b1));
                end else begin
                    shadow_stack[shadow_fill] = value;
                    shadow_fill++;
                    stack_replies.push_back(make_reply(ST_OK, '0, 1'b0, 1'b1));
                end
            end
            OP_POP: begin
                if (shadow_fill == 0) begin
                    stack_replies.push_back(make_reply(ST_UNDERFLOW, '0, 1'b0, 1'b1));
                end else begin
                    shadow_fill--;
                    stack_replies.push_back(make_reply(ST_OK, shadow_stack[shadow_fill], 1'b0,
                                                       1'b1));
                end
            end
            OP_CHECK: begin
                if (shadow_fill == 0) begin
                    stack_replies.push_back(make_reply(ST_EMPTY, '0, 1'b0, 1'b1));
                end else begin
                    // every mirror pair has to match, not just the innermost one
                    mirrored = 1'b1;
                    for (i = 0; i < shadow_fill / 2; i++) begin
                        if (shadow_stack[i] != shadow_stack[shadow_fill - 1 - i]) begin
                            mirrored = 1'b0;
                        end
                    end
                    stack_replies.push_back(make_reply(ST_OK, '0, mirrored, 1'b1));
                end
            end
            default: begin
                if (shadow_fill == 0) begin
                    stack_replies.push_back(make_reply(ST_EMPTY, '0, 1'b0, 1'b1));
                end else begin
                    for (i = 0; i < shadow_fill; i++) begin
                        stack_replies.push_back(make_reply(ST_OK,
                            shadow_stack[shadow_fill - 1 - i], 1'b0, i + 1 == shadow_fill));
                    end
                end
            end
        endcase
    endfunction

    task automatic queue_request(input t_op op, input logic [31:0] value);
        t_stack_request req;
        req.op = op;
        req.value = value;
        stack_requests.push_back(req);
        requests_queued++;
        if (op == OP_PUSH && planned_fill < StackDepth) begin
            planned_fill++;
        end else if (op == OP_POP && planned_fill > 0) begin
            planned_fill--;
        end
    endtask

    // Mix of full-range, small, extreme and small negative values
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(3);
            2: begin
                case ($urandom_range(3))
                    0: v = MinInt;
                    1: v = MaxInt;
                    2: v = '1;
                    default: v = '0;
                endcase
            end
            default: v = -$urandom_range(1, 4);
        endcase
        return v;
    endfunction

    // Empty the stack, build a mirrored run (sometimes spoiled), then inspect it
    task automatic queue_palindrome_run();
        logic [31:0] run_vals[StackDepth];
        int unsigned run_len;
        int unsigned i;
        int unsigned spoil;
        while (planned_fill > 0) begin
            queue_request(OP_POP, random_value());
        end
        run_len = ($urandom_range(3) == 0) ? StackDepth : $urandom_range(1, StackDepth);
        for (i = 0; i < run_len; i++) begin
            run_vals[i] = (i < run_len - 1 - i) ? random_value() : run_vals[run_len - 1 - i];
        end
        if ($urandom_range(1) == 1) begin
            spoil = $urandom_range(run_len - 1);
            run_vals[spoil] = run_vals[spoil] ^ (32'd1 << $urandom_range(31));
        end
        for (i = 0; i < run_len; i++) begin
            queue_request(OP_PUSH, run_vals[i]);
        end
        queue_request(OP_CHECK, random_value());
        if (planned_fill == StackDepth && $urandom_range(1) == 1) begin
            queue_request(OP_PUSH, random_value());
        end
        if ($urandom_range(1) == 1) begin
            queue_request(OP_DUMP, random_value());
        end
    endtask

    task automatic wait_drained();
        while (requests_sent != requests_queued || stack_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: record accepted transfers, then present the next request or idle
    always @(posedge i_clk) begin : driver_proc
        t_stack_request next_req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                apply_stack_request(t_op'(s_axis_tuser), s_axis_tdata);
                requests_sent++;
            end
            if (stack_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = stack_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= next_req.op;
                s_axis_tdata <= next_req.value;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each output transfer with the oldest predicted result
    always @(posedge i_clk) begin : monitor_proc
        t_stack_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (stack_replies.size() == 0) begin
                    report_mismatch("unexpected result", 64'({m_axis_tuser, m_axis_tdata}),
                                    '0);
                end else begin
                    want = stack_replies.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                    end
                    if (m_axis_tdata[31:0] !== want.item) begin
                        report_mismatch("item", 64'(m_axis_tdata[31:0]), 64'(want.item));
                    end
                    if (m_axis_tdata[32] !== want.pal) begin
                        report_mismatch("is_palindrome", 64'(m_axis_tdata[32]),
                                        64'(want.pal));
                    end
                    if (m_axis_tdata[39:33] !== '0) begin
                        report_mismatch("tdata padding", 64'(m_axis_tdata[39:33]), '0);
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
            if (hang_cycles + 1 >= HangLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus_proc
        int unsigned send_pcts[4];
        int unsigned recv_pcts[4];
        int unsigned phase;
        int unsigned goal;
        send_pcts = '{0, 85, 0, 35};
        recv_pcts = '{0, 0, 85, 35};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty stack, single element, full stack, inner-pair mismatch
        queue_request(OP_CHECK, 32'h0);
        queue_request(OP_POP, 32'hFFFF_FFFF);
        queue_request(OP_DUMP, 32'h0);
        queue_request(OP_PUSH, MinInt);
        queue_request(OP_CHECK, 32'h0);
        queue_request(OP_PUSH, MaxInt);
        queue_request(OP_CHECK, 32'h0);
        queue_request(OP_POP, 32'h0);
        queue_request(OP_PUSH, 32'h0000_0001);
        queue_request(OP_PUSH, 32'hFFFF_FFFE);
        queue_request(OP_PUSH, 32'h5A5A_A5A5);
        queue_request(OP_PUSH, 32'h5A5A_A5A5);
        queue_request(OP_PUSH, 32'hFFFF_FFFE);
        queue_request(OP_PUSH, 32'h0000_0001);
        queue_request(OP_PUSH, MinInt);
        queue_request(OP_CHECK, 32'h0);
        queue_request(OP_PUSH, 32'h5555_5555);
        queue_request(OP_DUMP, 32'h0);
        queue_request(OP_POP, 32'h0);
        queue_request(OP_PUSH, 32'hFFFF_FFFF);
        queue_request(OP_CHECK, 32'h0);
        queue_request(OP_POP, 32'h0);
        queue_request(OP_POP, 32'h0);
        queue_request(OP_PUSH, 32'h0000_0002);
        queue_request(OP_PUSH, MinInt);
        queue_request(OP_CHECK, 32'h0);
        wait_drained();

        // Random: palindrome runs with some noise, under each idle pattern
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            goal = requests_queued + RandomPerPhase;
            while (requests_queued < goal) begin
                if ($urandom_range(3) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        queue_request(t_op'($urandom_range(3)), random_value());
                    end
                end else begin
                    queue_palindrome_run();
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && stack_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== bounded_stack_palindrome_check_unit.f =====
rtl/core/bspc_pkg.sv
rtl/core/bspc_dpath.sv
rtl/core/bspc_ctrl.sv
rtl/core/bounded_stack_palindrome_check_unit.sv
tb/bounded_stack_palindrome_check_unit_test.sv
